// ----- design/tilemap_rect_collision_scan_top_macros.svh -----
// assertion macros shared by the tile map collision scan rtl
`ifndef TILEMAP_RECT_COLLISION_SCAN_TOP_MACROS_SVH
`define TILEMAP_RECT_COLLISION_SCAN_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define TMRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tmrc_pkg.sv -----
// shared types and constants of the tile map collision scan
`default_nettype none

package tmrc_pkg;

    localparam int RECT_W    = 20;
    localparam int FRAC_BITS = 4;
    localparam int CFG_W     = 8;

    localparam logic [7:0] MAP_WIDTH_RESET  = 8'd128;
    localparam logic [6:0] MAP_HEIGHT_RESET = 7'd64;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_WR,
        ST_SEARCH,
        ST_MASK,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_COL_HI,
        SEL_COL_LO,
        SEL_ROW_HI,
        SEL_ROW_LO
    } sel_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [6:0]                tile_col;
        logic [5:0]                tile_row;
        logic [15:0]               tile_value;
        logic signed [RECT_W-1:0]  rect_left;
        logic signed [RECT_W-1:0]  rect_top;
        logic signed [RECT_W-1:0]  rect_right;
        logic signed [RECT_W-1:0]  rect_bottom;
    } item_t;

    typedef struct packed {
        logic        hit;
        logic [11:0] tile_left;
        logic [10:0] tile_top;
        logic [12:0] tile_right;
        logic [11:0] tile_bottom;
    } result_t;

    typedef struct packed {
        logic [7:0] map_width;
        logic [6:0] map_height;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/tilemap_rect_collision_scan_top.sv -----
// top level of the tile map versus rectangle collision scan
// map write: busy while the read row is written back with the new tile bit, no result
// query: 4 bound searches of 8 steps, a mask step, a read and a check per row scanned,
// and a finish step; the scan stops at the first row with a hit; the result strobe is registered
// result strobe lasts one cycle and cannot be held off; a new item may start meanwhile
// reset: all tiles empty at once through per-row valid bits, map 128 x 64
`default_nettype none

`include "tilemap_rect_collision_scan_top_macros.svh"

module tilemap_rect_collision_scan_top #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TILE_PIXELS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire tmrc_pkg::item_t               item,
    output logic                               busy,
    output logic                               done,
    output tmrc_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire tmrc_pkg::cfg_idx_t            cfg_index,
    input  wire logic [tmrc_pkg::CFG_W-1:0]    cfg_data
);

    localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [7:0]         map_width_reg, map_width_next;
    logic [6:0]         map_height_reg, map_height_next;
    tmrc_pkg::cfg_t     cfg;

    logic [RA-1:0]       ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;
    logic                ram_we;
    logic [RA-1:0]       ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;

    always_comb
    begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tmrc_pkg::CFG_MAP_WIDTH:  map_width_next  = cfg_data[7:0];
                tmrc_pkg::CFG_MAP_HEIGHT: map_height_next = cfg_data[6:0];
                default:                  map_width_next  = map_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= tmrc_pkg::MAP_WIDTH_RESET;
            map_height_reg <= tmrc_pkg::MAP_HEIGHT_RESET;
        end
        else
        begin
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
        end
    end

    assign cfg.map_width  = map_width_reg;
    assign cfg.map_height = map_height_reg;

    tmrc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tmrc_ctrl #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .TILE_PIXELS (TILE_PIXELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    `TMRC_ASSERT_NEXT(a_query_busy, clk, rst_n,
                      start && !busy && item.cmd == tmrc_pkg::CMD_QUERY,
                      busy && !done, "query transaction did not start a scan")
    `TMRC_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy || $past(start),
                     "result strobe while scan still running")

endmodule

`default_nettype wire

// ----- design/tmrc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module tmrc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/tmrc_cmp_unit.sv -----
// shared multiply and compare unit: tests n * step < bound
`default_nettype none

module tmrc_cmp_unit #(
    parameter int NB   = 8,
    parameter int PW   = 24,
    parameter int STEP = 512
) (
    input  wire logic        [NB-1:0] n,
    input  wire logic signed [PW-1:0] bound,
    output logic                      lt
);

    logic [PW-1:0] prod;

    assign prod = PW'(n) * PW'(STEP);
    assign lt   = $signed(prod) < bound;

endmodule

`default_nettype wire

// ----- design/tmrc_ctrl.sv -----
// sequencer: bound search, row scan, map writes and result register
`default_nettype none

`include "tilemap_rect_collision_scan_top_macros.svh"

module tmrc_ctrl #(
    parameter int  MAX_COLS    = 128,
    parameter int  MAX_ROWS    = 64,
    parameter int  TILE_PIXELS = 32,
    localparam int RA          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tmrc_pkg::item_t     item,
    input  wire tmrc_pkg::cfg_t      cfg,
    output logic                     busy,
    output logic                     done,
    output tmrc_pkg::result_t        result,
    output logic [RA-1:0]            ram_raddr,
    input  wire logic [MAX_COLS-1:0] ram_rdata,
    output logic                     ram_we,
    output logic [RA-1:0]            ram_waddr,
    output logic [MAX_COLS-1:0]      ram_wdata
);

    localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int NB   = $clog2(MAXD + 1);
    localparam int BB   = (NB > 1) ? $clog2(NB) : 1;
    localparam int CA   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int STEP = TILE_PIXELS * (1 << tmrc_pkg::FRAC_BITS);
    localparam int SB   = $clog2(STEP + 1);
    localparam int PW   = ((NB + SB) > (tmrc_pkg::RECT_W + 1) ?
                           (NB + SB) : (tmrc_pkg::RECT_W + 1)) + 1;
    localparam int EW   = NB + 14;
    localparam int RW   = tmrc_pkg::RECT_W;

    tmrc_pkg::state_t state_reg, state_next;
    tmrc_pkg::sel_t   sel_reg, sel_next;
    logic [BB-1:0]    bit_reg, bit_next;
    logic [NB-1:0]    q_reg, q_next;
    logic             done_reg, done_next;
    logic [MAX_ROWS-1:0] row_valid_reg, row_valid_next;

    logic [NB-1:0]    col_lo_reg, col_lo_next;
    logic [NB-1:0]    col_hi_reg, col_hi_next;
    logic [NB-1:0]    row_lo_reg, row_lo_next;
    logic [NB-1:0]    row_hi_reg, row_hi_next;
    logic [NB-1:0]    row_reg, row_next;
    logic [NB-1:0]    row_end_reg, row_end_next;
    logic [MAX_COLS-1:0] mask_reg, mask_next;
    logic signed [RW-1:0] left_reg, left_next;
    logic signed [RW-1:0] top_reg, top_next;
    logic signed [RW-1:0] right_reg, right_next;
    logic signed [RW-1:0] bottom_reg, bottom_next;
    logic [CA-1:0]    wr_col_reg, wr_col_next;
    logic [RA-1:0]    wr_row_reg, wr_row_next;
    logic             wr_bit_reg, wr_bit_next;
    logic             found_reg, found_next;
    logic [CA-1:0]    found_col_reg, found_col_next;
    logic [RA-1:0]    found_row_reg, found_row_next;
    tmrc_pkg::result_t result_reg, result_next;

    logic [NB-1:0]        cand;
    logic [NB-1:0]        q_upd;
    logic signed [PW-1:0] bound;
    logic                 lt;
    logic                 last_bit;
    logic                 wr_in_range;
    logic [NB-1:0]        w_eff;
    logic [NB-1:0]        h_eff;
    logic [NB-1:0]        col_end;
    logic [NB-1:0]        row_end;
    logic [MAX_COLS-1:0]  row_data;
    logic [MAX_COLS-1:0]  row_hits;
    logic                 row_any;
    logic [CA-1:0]        first_col;
    logic [NB-1:0]        row_inc;
    logic [MAX_COLS-1:0]  wr_base;
    logic [EW-1:0]        edge_left;
    logic [EW-1:0]        edge_top;
    logic [EW-1:0]        edge_right;
    logic [EW-1:0]        edge_bottom;

    tmrc_cmp_unit #(
        .NB   (NB),
        .PW   (PW),
        .STEP (STEP)
    ) u_cmp (
        .n     (cand),
        .bound (bound),
        .lt    (lt)
    );

    // shared datapath terms
    always_comb
    begin
        cand     = q_reg | (NB'(1) << bit_reg);
        q_upd    = lt ? cand : q_reg;
        last_bit = (bit_reg == '0);
        case (sel_reg)
            tmrc_pkg::SEL_COL_HI: bound = PW'(right_reg) + PW'(STEP) + PW'(1);
            tmrc_pkg::SEL_COL_LO: bound = PW'(left_reg);
            tmrc_pkg::SEL_ROW_HI: bound = PW'(bottom_reg) + PW'(STEP) + PW'(1);
            tmrc_pkg::SEL_ROW_LO: bound = PW'(top_reg);
            default:              bound = PW'(left_reg);
        endcase

        wr_in_range = (32'(item.tile_col) < 32'(MAX_COLS)) &&
                      (32'(item.tile_row) < 32'(MAX_ROWS));

        w_eff = (32'(cfg.map_width) < 32'(MAX_COLS)) ?
                NB'(cfg.map_width) : NB'(MAX_COLS);
        h_eff = (32'(cfg.map_height) < 32'(MAX_ROWS)) ?
                NB'(cfg.map_height) : NB'(MAX_ROWS);
        col_end = (col_hi_reg < w_eff) ? col_hi_reg : w_eff;
        row_end = (row_hi_reg < h_eff) ? row_hi_reg : h_eff;

        row_data = row_valid_reg[row_reg[RA-1:0]] ? ram_rdata : '0;
        row_hits = row_data & mask_reg;
        row_any  = |row_hits;
        first_col = '0;
        for (int x = MAX_COLS - 1; x >= 0; x--)
        begin
            if (row_hits[x])
            begin
                first_col = CA'(x);
            end
        end
        row_inc = row_reg + NB'(1);

        wr_base = row_valid_reg[wr_row_reg] ? ram_rdata : '0;

        edge_left   = EW'(found_col_reg) * EW'(TILE_PIXELS);
        edge_top    = EW'(found_row_reg) * EW'(TILE_PIXELS);
        edge_right  = edge_left + EW'(TILE_PIXELS);
        edge_bottom = edge_top + EW'(TILE_PIXELS);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmrc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (item.cmd == tmrc_pkg::CMD_QUERY)
                    begin
                        state_next = tmrc_pkg::ST_SEARCH;
                    end
                    else if (wr_in_range)
                    begin
                        state_next = tmrc_pkg::ST_WR_WR;
                    end
                end
            end
            tmrc_pkg::ST_WR_WR:
            begin
                state_next = tmrc_pkg::ST_IDLE;
            end
            tmrc_pkg::ST_SEARCH:
            begin
                if (last_bit && sel_reg == tmrc_pkg::SEL_ROW_LO)
                begin
                    state_next = tmrc_pkg::ST_MASK;
                end
            end
            tmrc_pkg::ST_MASK:
            begin
                state_next = (row_lo_reg < row_end) ? tmrc_pkg::ST_ROW_RD
                                                    : tmrc_pkg::ST_DONE;
            end
            tmrc_pkg::ST_ROW_RD:
            begin
                state_next = tmrc_pkg::ST_ROW_CHK;
            end
            tmrc_pkg::ST_ROW_CHK:
            begin
                if (row_any || row_inc >= row_end_reg)
                begin
                    state_next = tmrc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tmrc_pkg::ST_ROW_RD;
                end
            end
            tmrc_pkg::ST_DONE:
            begin
                state_next = tmrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tmrc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sel_next       = sel_reg;
        bit_next       = bit_reg;
        q_next         = q_reg;
        done_next      = 1'b0;
        row_valid_next = row_valid_reg;
        col_lo_next    = col_lo_reg;
        col_hi_next    = col_hi_reg;
        row_lo_next    = row_lo_reg;
        row_hi_next    = row_hi_reg;
        row_next       = row_reg;
        row_end_next   = row_end_reg;
        mask_next      = mask_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        right_next     = right_reg;
        bottom_next    = bottom_reg;
        wr_col_next    = wr_col_reg;
        wr_row_next    = wr_row_reg;
        wr_bit_next    = wr_bit_reg;
        found_next     = found_reg;
        found_col_next = found_col_reg;
        found_row_next = found_row_reg;
        result_next    = result_reg;
        ram_raddr      = row_reg[RA-1:0];
        ram_we         = 1'b0;
        ram_waddr      = wr_row_reg;
        ram_wdata      = wr_base;
        ram_wdata[wr_col_reg] = wr_bit_reg;

        case (state_reg)
            tmrc_pkg::ST_IDLE:
            begin
                ram_raddr   = RA'(item.tile_row);
                wr_col_next = CA'(item.tile_col);
                wr_row_next = RA'(item.tile_row);
                wr_bit_next = |item.tile_value;
                left_next   = item.rect_left;
                top_next    = item.rect_top;
                right_next  = item.rect_right;
                bottom_next = item.rect_bottom;
                sel_next    = tmrc_pkg::SEL_COL_HI;
                bit_next    = BB'(NB - 1);
                q_next      = '0;
            end
            tmrc_pkg::ST_WR_WR:
            begin
                ram_we = 1'b1;
                row_valid_next[wr_row_reg] = 1'b1;
            end
            tmrc_pkg::ST_SEARCH:
            begin
                q_next   = q_upd;
                bit_next = bit_reg - BB'(1);
                if (last_bit)
                begin
                    q_next   = '0;
                    bit_next = BB'(NB - 1);
                    case (sel_reg)
                        tmrc_pkg::SEL_COL_HI:
                        begin
                            col_hi_next = (32'(q_upd) > 32'(MAX_COLS)) ?
                                          NB'(MAX_COLS) : q_upd;
                            sel_next    = tmrc_pkg::SEL_COL_LO;
                        end
                        tmrc_pkg::SEL_COL_LO:
                        begin
                            col_lo_next = (32'(q_upd) > 32'(MAX_COLS)) ?
                                          NB'(MAX_COLS) : q_upd;
                            sel_next    = tmrc_pkg::SEL_ROW_HI;
                        end
                        tmrc_pkg::SEL_ROW_HI:
                        begin
                            row_hi_next = (32'(q_upd) > 32'(MAX_ROWS)) ?
                                          NB'(MAX_ROWS) : q_upd;
                            sel_next    = tmrc_pkg::SEL_ROW_LO;
                        end
                        default:
                        begin
                            row_lo_next = (32'(q_upd) > 32'(MAX_ROWS)) ?
                                          NB'(MAX_ROWS) : q_upd;
                            sel_next    = tmrc_pkg::SEL_COL_HI;
                        end
                    endcase
                end
            end
            tmrc_pkg::ST_MASK:
            begin
                for (int x = 0; x < MAX_COLS; x++)
                begin
                    mask_next[x] = (NB'(x) >= col_lo_reg) && (NB'(x) < col_end);
                end
                row_end_next = row_end;
                row_next     = row_lo_reg;
                found_next   = 1'b0;
            end
            tmrc_pkg::ST_ROW_RD:
            begin
                ram_raddr = row_reg[RA-1:0];
            end
            tmrc_pkg::ST_ROW_CHK:
            begin
                if (row_any)
                begin
                    found_next     = 1'b1;
                    found_col_next = first_col;
                    found_row_next = row_reg[RA-1:0];
                end
                else
                begin
                    row_next = row_inc;
                end
            end
            tmrc_pkg::ST_DONE:
            begin
                done_next = 1'b1;
                if (found_reg)
                begin
                    result_next.hit         = 1'b1;
                    result_next.tile_left   = edge_left[11:0];
                    result_next.tile_top    = edge_top[10:0];
                    result_next.tile_right  = edge_right[12:0];
                    result_next.tile_bottom = edge_bottom[11:0];
                end
                else
                begin
                    result_next = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmrc_pkg::ST_IDLE;
            sel_reg       <= tmrc_pkg::SEL_COL_HI;
            bit_reg       <= '0;
            q_reg         <= '0;
            done_reg      <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            bit_reg       <= bit_next;
            q_reg         <= q_next;
            done_reg      <= done_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        col_lo_reg    <= col_lo_next;
        col_hi_reg    <= col_hi_next;
        row_lo_reg    <= row_lo_next;
        row_hi_reg    <= row_hi_next;
        row_reg       <= row_next;
        row_end_reg   <= row_end_next;
        mask_reg      <= mask_next;
        left_reg      <= left_next;
        top_reg       <= top_next;
        right_reg     <= right_next;
        bottom_reg    <= bottom_next;
        wr_col_reg    <= wr_col_next;
        wr_row_reg    <= wr_row_next;
        wr_bit_reg    <= wr_bit_next;
        found_reg     <= found_next;
        found_col_reg <= found_col_next;
        found_row_reg <= found_row_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != tmrc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `TMRC_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg,
                      "result strobe longer than one cycle")
    `TMRC_ASSERT_NOW(a_row_in_range, clk, rst_n, state_reg == tmrc_pkg::ST_ROW_CHK,
                     row_reg < row_end_reg, "row scan beyond end row")
    `TMRC_ASSERT_NOW(a_miss_zero, clk, rst_n, done_reg && !result_reg.hit,
                     result_reg.tile_left == '0 && result_reg.tile_right == '0 &&
                     result_reg.tile_bottom == '0, "miss with nonzero edges")

endmodule

`default_nettype wire
